>>> hw/rtl/ibt_pkg.sv
// Shared types and constants for the interval breakpoint table.
// Used by ibt_table and interval_breakpoint_table; depends on nothing.
package ibt_pkg;

  localparam int unsigned TableDepth = 32;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned AddrW      = IdxW + 1;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_IGNORED = 2'd1,
    STS_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0] val;
    logic [31:0] key;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    entry_t           data;
  } wr_req_t;

  // signed order of two raw keys: a < b
  function automatic logic key_less(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

>>> hw/rtl/ibt_table.sv
// Two-bank breakpoint store: one write port, one read port with registered data.
// Depends on ibt_pkg.
module ibt_table
  import ibt_pkg::*;
(
  input  logic             clk_i,
  input  wr_req_t          wr_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output entry_t           rd_data_o
);

  entry_t mem_q [2**AddrW];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

>>> hw/rtl/interval_breakpoint_table.sv
// Interval breakpoint table: range add / set / clear over a sorted breakpoint list.
// Each command scans the stored entries, merges them with the range into the spare bank,
// then emits one word per entry of the new table (at least one word); an ignored, clear
// or unused command goes straight to emission, and a full table skips the merge. Output
// stalls hold back emission. One command at a time, set by the single read port of the
// table store walked once per pass. Reset (rst_ni low, asynchronous): table empty, no word pending, ready.
// Depends on ibt_pkg and ibt_table.
module interval_breakpoint_table
  import ibt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // range_from[31:0], range_to[63:32], amount[95:64]
  input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // point[31:0], intensity[63:32]
  output logic [2:0]  m_axis_tuser,  // entry_valid[0], status[2:1]
  output logic        m_axis_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MERGE,
    ST_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  rp_q, rp_d;     // read pointer into the live bank
  logic [CntW-1:0]  wp_q, wp_d;     // write pointer into the spare bank
  logic [CntW-1:0]  n_q, n_d;       // entries held
  logic             cur_q, cur_d;   // live bank
  opcode_e          op_q, op_d;
  logic [31:0]      from_q, from_d;
  logic [31:0]      to_q, to_d;
  logic [31:0]      amt_q, amt_d;
  logic             ff_q, ff_d;     // range_from already a breakpoint
  logic             ft_q, ft_d;     // range_to already a breakpoint
  status_e          sts_q, sts_d;
  logic             fdone_q, fdone_d;
  logic             tdone_q, tdone_d;
  logic [31:0]      prev_q, prev_d;  // unmodified value of the previous working entry
  logic [31:0]      kept_q, kept_d;  // value of the last kept entry
  logic             havek_q, havek_d;
  logic             ov_q, ov_d;
  logic [63:0]      od_q, od_d;
  logic [2:0]       ou_q, ou_d;
  logic             ol_q, ol_d;

  wr_req_t          wr;
  entry_t           rd;
  logic [AddrW-1:0] rd_addr;

  // merge datapath
  logic             have;
  logic             is_from, is_to, is_old, hit, inr, touch;
  logic [31:0]      ekey, eorig, emod;
  logic [CntW:0]    need;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = ou_q;
  assign m_axis_tlast  = ol_q;

  // Address from the next pointer so the registered read data matches rp_q.
  assign rd_addr = {cur_d, rp_d[IdxW-1:0]};

  ibt_table u_table (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd)
  );

  always_comb begin
    have    = (rp_q < n_q);
    is_from = !fdone_q && (!have || !key_less(rd.key, from_q));
    is_to   = !is_from && fdone_q && !tdone_q && (!have || !key_less(rd.key, to_q));
    is_old  = !is_from && !is_to && have;
    hit     = have && ((is_from && (rd.key == from_q)) || (is_to && (rd.key == to_q)));
    ekey    = rd.key;
    eorig   = rd.val;
    if ((is_from || is_to) && !hit) begin
      // new end takes the value in force just before it
      ekey  = is_from ? from_q : to_q;
      eorig = prev_q;
    end
    inr   = is_from || (fdone_q && !tdone_q && !is_to);
    touch = is_from || is_to || (fdone_q && !tdone_q);
    if (inr) begin
      emod = (op_q == OP_ADD) ? (eorig + amt_q) : amt_q;
    end else begin
      emod = eorig;
    end
    need = {1'b0, n_q} + (CntW+1)'(!ff_q) + (CntW+1)'(!ft_q);
  end

  always_comb begin
    state_d = state_q;
    rp_d    = rp_q;
    wp_d    = wp_q;
    n_d     = n_q;
    cur_d   = cur_q;
    op_d    = op_q;
    from_d  = from_q;
    to_d    = to_q;
    amt_d   = amt_q;
    ff_d    = ff_q;
    ft_d    = ft_q;
    sts_d   = sts_q;
    fdone_d = fdone_q;
    tdone_d = tdone_q;
    prev_d  = prev_q;
    kept_d  = kept_q;
    havek_d = havek_q;
    ov_d    = ov_q;
    od_d    = od_q;
    ou_d    = ou_q;
    ol_d    = ol_q;
    wr      = '0;

    // drop the pending word once taken
    if (m_axis_tready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d   = opcode_e'(s_axis_tuser);
          from_d = s_axis_tdata[31:0];
          to_d   = s_axis_tdata[63:32];
          amt_d  = s_axis_tdata[95:64];
          rp_d   = '0;
          sts_d  = STS_DONE;
          ff_d   = 1'b0;
          ft_d   = 1'b0;
          state_d = ST_EMIT;
          case (opcode_e'(s_axis_tuser))
            OP_ADD, OP_SET: begin
              if (key_less(s_axis_tdata[31:0], s_axis_tdata[63:32])) begin
                state_d = ST_SCAN;
              end else begin
                sts_d = STS_IGNORED;
              end
            end
            OP_CLEAR: n_d = '0;
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        if (have) begin
          ff_d = ff_q | (rd.key == from_q);
          ft_d = ft_q | (rd.key == to_q);
          rp_d = rp_q + CntW'(1);
        end else begin
          rp_d = '0;
          if (need > (CntW+1)'(TableDepth)) begin
            sts_d   = STS_FULL;
            state_d = ST_EMIT;
          end else begin
            wp_d    = '0;
            fdone_d = 1'b0;
            tdone_d = 1'b0;
            prev_d  = '0;
            havek_d = 1'b0;
            state_d = ST_MERGE;
          end
        end
      end

      ST_MERGE: begin
        if (is_from || is_to || is_old) begin
          if (is_old || hit) begin
            rp_d = rp_q + CntW'(1);
          end
          if (is_from) begin
            fdone_d = 1'b1;
          end
          if (is_to) begin
            tdone_d = 1'b1;
          end
          prev_d = eorig;
          // fold entries equal to the kept one before, inside the touched span
          if (!(touch && havek_q && (emod == kept_q))) begin
            kept_d  = emod;
            havek_d = 1'b1;
            // hold back leading zero intensity
            if ((wp_q != '0) || (emod != '0)) begin
              wr.en   = 1'b1;
              wr.addr = {~cur_q, wp_q[IdxW-1:0]};
              wr.data = '{val: emod, key: ekey};
              wp_d    = wp_q + CntW'(1);
            end
          end
        end else begin
          cur_d   = ~cur_q;
          n_d     = wp_q;
          rp_d    = '0;
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (!ov_q || m_axis_tready) begin
          ov_d = 1'b1;
          if (n_q == '0) begin
            od_d    = '0;
            ou_d    = {sts_q, 1'b0};
            ol_d    = 1'b1;
            state_d = ST_IDLE;
          end else begin
            od_d = {rd.val, rd.key};
            ou_d = {sts_q, 1'b1};
            ol_d = (rp_q == n_q - CntW'(1));
            rp_d = rp_q + CntW'(1);
            if (rp_q == n_q - CntW'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rp_q    <= '0;
      wp_q    <= '0;
      n_q     <= '0;
      cur_q   <= 1'b0;
      op_q    <= OP_NONE;
      from_q  <= '0;
      to_q    <= '0;
      amt_q   <= '0;
      ff_q    <= 1'b0;
      ft_q    <= 1'b0;
      sts_q   <= STS_DONE;
      fdone_q <= 1'b0;
      tdone_q <= 1'b0;
      prev_q  <= '0;
      kept_q  <= '0;
      havek_q <= 1'b0;
      ov_q    <= 1'b0;
      od_q    <= '0;
      ou_q    <= '0;
      ol_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rp_q    <= rp_d;
      wp_q    <= wp_d;
      n_q     <= n_d;
      cur_q   <= cur_d;
      op_q    <= op_d;
      from_q  <= from_d;
      to_q    <= to_d;
      amt_q   <= amt_d;
      ff_q    <= ff_d;
      ft_q    <= ft_d;
      sts_q   <= sts_d;
      fdone_q <= fdone_d;
      tdone_q <= tdone_d;
      prev_q  <= prev_d;
      kept_q  <= kept_d;
      havek_q <= havek_d;
      ov_q    <= ov_d;
      od_q    <= od_d;
      ou_q    <= ou_d;
      ol_q    <= ol_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CntW'(TableDepth))
    else $error("entry count beyond table depth");

  a_merge_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> (wp_q <= CntW'(TableDepth)))
    else $error("merge wrote beyond table depth");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q != ST_IDLE))
    else $error("command accepted without leaving idle");

  a_empty_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("empty-table word not marked last");

endmodule

>>> tb/interval_breakpoint_table_chk.sv
// Checker for the interval breakpoint table: watches both streams, keeps its own
// breakpoint table and compares every emitted word. Depends on ibt_pkg.
module interval_breakpoint_table_chk
  import ibt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0] point;
    logic [31:0] intensity;
    logic        entry_valid;
    logic        last;
    status_e     status;
  } table_word_t;

  logic [31:0]  bp_keys[$];
  logic [31:0]  bp_vals[$];
  table_word_t  words_due[$];

  function automatic bit lt(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic int put_end(ref logic [31:0] k[$], ref logic [31:0] v[$],
                                 input logic [31:0] key);
    int pos;
    pos = 0;
    while (pos < k.size() && lt(k[pos], key)) pos++;
    if (pos < k.size() && k[pos] == key) return pos;
    k.insert(pos, key);
    v.insert(pos, (pos > 0) ? v[pos-1] : 32'd0);
    return pos;
  endfunction

  // Apply one command to the shadow table and queue the words it emits.
  task automatic apply_command(opcode_e op, logic [31:0] from, logic [31:0] to,
                               logic [31:0] amt);
    logic [31:0] k[$];
    logic [31:0] v[$];
    logic [31:0] nk[$];
    logic [31:0] nv[$];
    status_e sts;
    int s, e;
    table_word_t w;
    sts = STS_DONE;
    if (op == OP_ADD || op == OP_SET) begin
      if (!lt(from, to)) begin
        sts = STS_IGNORED;
      end else begin
        k = bp_keys;
        v = bp_vals;
        s = put_end(k, v, from);
        e = put_end(k, v, to);
        s = put_end(k, v, from);
        if (k.size() > TableDepth) begin
          sts = STS_FULL;
        end else begin
          for (int i = s; i < e; i++) v[i] = (op == OP_ADD) ? v[i] + amt : amt;
          // merge equal neighbours within the touched span
          for (int i = 0; i < k.size(); i++) begin
            if (i >= s && i <= e && nk.size() > 0 && v[i] == nv[nv.size()-1]) continue;
            nk.push_back(k[i]);
            nv.push_back(v[i]);
          end
          // drop leading zero intensities
          while (nv.size() > 0 && nv[0] == 32'd0) begin
            void'(nk.pop_front());
            void'(nv.pop_front());
          end
          bp_keys = nk;
          bp_vals = nv;
        end
      end
    end else if (op == OP_CLEAR) begin
      bp_keys.delete();
      bp_vals.delete();
    end
    if (bp_keys.size() == 0) begin
      w = '{32'd0, 32'd0, 1'b0, 1'b1, sts};
      words_due.push_back(w);
    end else begin
      for (int i = 0; i < bp_keys.size(); i++) begin
        w = '{bp_keys[i], bp_vals[i], 1'b1, i == bp_keys.size() - 1, sts};
        words_due.push_back(w);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    table_word_t got, exp_w;
    if (!rst_ni) begin
      fail_count_o <= 0;
      bp_keys.delete();
      bp_vals.delete();
      words_due.delete();
    end else begin
      // compare before predicting so a word never meets its own command
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser[0], m_axis_tlast,
                status_e'(m_axis_tuser[2:1])};
        if (words_due.size() == 0) begin
          $display("%0t: unexpected word got %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_w = words_due.pop_front();
          if (got !== exp_w) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_w, got);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        apply_command(opcode_e'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[63:32],
                      s_axis_tdata[95:64]);
    end
  end

  assign pending_o = words_due.size();

endmodule

>>> tb/interval_breakpoint_table_tb.sv
// Top of the interval breakpoint table testbench: clock, reset, command stimulus,
// output back-pressure and verdict. Depends on ibt_pkg, the block and its checker.
module interval_breakpoint_table_tb;
  import ibt_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  bit          rand_stall;

  localparam int WatchdogLimit = 3000;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  interval_breakpoint_table dut (.*);

  interval_breakpoint_table_chk chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending));

  // Watchdog: count cycles with no word moving on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: hold ready low for a random stretch per word, or not at all.
  initial begin
    int gap;
    forever begin
      @(posedge clk_i);
      if (m_axis_tready && m_axis_tvalid || !m_axis_tready) begin
        gap = rand_stall ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Keys from a narrow pool so ranges overlap and the table fills up.
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      default: return $urandom_range(0, 40) - 20;
    endcase
  endfunction

  // Valid stays high after the accepting edge; the next call or the caller drops it.
  task automatic send_cmd(opcode_e op, logic [31:0] from, logic [31:0] to,
                          logic [31:0] amt, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {amt, to, from};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random(int gap);
    logic [31:0] a, b, amt;
    opcode_e op;
    int r;
    a = pick_key();
    b = pick_key();
    if ($urandom_range(0, 4) != 0 && $signed(a) > $signed(b)) {a, b} = {b, a};
    r = $urandom_range(0, 99);
    op = (r < 50) ? OP_ADD : (r < 92) ? OP_SET : (r < 96) ? OP_CLEAR : OP_NONE;
    amt = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(0, 3) == 0 ?
          $urandom() : $urandom_range(0, 6) - 3;
    send_cmd(op, a, b, amt, gap);
  endtask

  initial begin
    rand_stall = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every opcode, empty range, wrap, clear, unused code.
    send_cmd(OP_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 0);
    send_cmd(OP_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'd1, 0);
    send_cmd(OP_SET, 32'd5, 32'd5, 32'd9, 0);
    send_cmd(OP_ADD, 32'd10, 32'hffff_fff6, 32'd3, 0);
    send_cmd(OP_SET, 32'hffff_fff0, 32'd20, 32'h7fff_ffff, 0);
    send_cmd(OP_ADD, 32'd0, 32'd4, 32'h8000_0001, 0);
    send_cmd(OP_ADD, 32'd2, 32'd6, 32'h8000_0000, 0);
    send_cmd(OP_SET, 32'd3, 32'd9, 32'd0, 0);
    send_cmd(OP_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0);
    send_cmd(OP_CLEAR, 32'd0, 32'd0, 32'd0, 0);
    // Fill the table with disjoint pieces until it reports full.
    for (int i = 0; i < 18; i++)
      send_cmd(OP_SET, 32'(i * 4), 32'(i * 4 + 2), 32'(i + 1), 0);
    send_cmd(OP_CLEAR, 32'd0, 32'd0, 32'd0, 0);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);

    // Hold off until every expected word has come.
    wait (pending == 0);

    rand_stall = 1'b1;
    for (int i = 0; i < 275; i++) begin
      if (i % 60 == 59) send_cmd(OP_CLEAR, 32'd0, 32'd0, 32'd0, 0);
      send_random(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14));
      if (i == 200) rand_stall = 1'b0;
      if (i == 240) rand_stall = 1'b1;
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);

    wait (pending == 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/ibt_pkg.sv
hw/rtl/ibt_table.sv
hw/rtl/interval_breakpoint_table.sv
tb/interval_breakpoint_table_chk.sv
tb/interval_breakpoint_table_tb.sv
